// ----- design/ultrasonic_range_filter_stop_top_assert.svh -----
// Assertion macros shared by the range filter checker.
`ifndef ULTRASONIC_RANGE_FILTER_STOP_TOP_ASSERT_SVH
`define ULTRASONIC_RANGE_FILTER_STOP_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define URFS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define URFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/urfs_pkg.sv -----
// Shared types, constants and field layout of the ultrasonic range filter.
package urfs_pkg;

    // Default echo counter width
    localparam int DEF_COUNT_BITS = 16;

    // Field widths
    localparam int TRIG_W   = 8;
    localparam int SCALE_W  = 12;
    localparam int WEIGHT_W = 9;
    localparam int DIST_W   = 20;
    localparam int TICKS_W  = 16;
    localparam int CFG_W    = 20;
    localparam int CFG_IDX_W = 3;

    // Second multiplier operand covers scale and both filter weights
    localparam int MB_W = SCALE_W;

    // Stream word widths
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 64;
    localparam int M_PAD_W  = M_DATA_W - (4 + TICKS_W + 2 * DIST_W);

    // Arithmetic constants
    localparam logic [DIST_W-1:0]   DIST_MAX   = {DIST_W{1'b1}};
    localparam logic [8:0]          ROUND_HALF = 9'd128;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

    // Register reset values
    localparam logic [TRIG_W-1:0]   RST_TRIGGER_TICKS = 8'd15;
    localparam logic [SCALE_W-1:0]  RST_SCALE_Q16     = 12'd1114;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_Q8     = 9'd179;
    localparam logic [DIST_W-1:0]   RST_NEAR          = 20'd6400;
    localparam logic [DIST_W-1:0]   RST_FAR           = 20'd8960;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIGGER_TICKS = 3'd0,
        CFG_SCALE_Q16     = 3'd1,
        CFG_WEIGHT_Q8     = 3'd2,
        CFG_NEAR          = 3'd3,
        CFG_FAR           = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [TRIG_W-1:0]   trigger_ticks;
        logic [SCALE_W-1:0]  scale_q16;
        logic [WEIGHT_W-1:0] filter_weight_q8;
        logic [DIST_W-1:0]   near_threshold;
        logic [DIST_W-1:0]   far_threshold;
    } cfg_t;

    // Measurement phase, advanced once per tick word
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_TRIG  = 2'd1,
        PH_WAIT  = 2'd2,
        PH_COUNT = 2'd3
    } phase_t;

    // Sequencer around the shared multiply-accumulate unit
    typedef enum logic [1:0] {
        SQ_IDLE = 2'd0,
        SQ_RAW  = 2'd1,
        SQ_FILT = 2'd2,
        SQ_DONE = 2'd3
    } seq_state_t;

    typedef enum logic [1:0] {
        MAC_HOLD  = 2'd0,
        MAC_START = 2'd1,
        MAC_ACC   = 2'd2
    } mac_op_t;

endpackage

// ----- design/urfs_mac.sv -----
// Shared multiply-accumulate unit with a registered accumulator.
module urfs_mac
    import urfs_pkg::*;
#(
    parameter int AW    = DIST_W,
    parameter int ACC_W = DIST_W + MB_W + 1
) (
    input  logic             aclk,
    input  mac_op_t          op,
    input  logic [AW-1:0]    a,
    input  logic [MB_W-1:0]  b,
    output logic [ACC_W-1:0] acc
);

    logic [AW+MB_W-1:0] prod;
    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   acc_next;

    assign prod = a * b;

    // Start a new sum with the rounding half, or add to the running one
    always_comb begin
        unique case (op)
            MAC_START: acc_next = ACC_W'(prod) + ACC_W'(ROUND_HALF);
            MAC_ACC:   acc_next = acc_reg + ACC_W'(prod);
            default:   acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// ----- design/urfs_ctrl.sv -----
// Tick phase logic, filter sequencer, hysteresis and output word register.
module urfs_ctrl
    import urfs_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    parameter int AW         = DIST_W,
    parameter int ACC_W      = DIST_W + MB_W + 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output mac_op_t             mac_op,
    output logic [AW-1:0]       mac_a,
    output logic [MB_W-1:0]     mac_b,
    input  logic [ACC_W-1:0]    mac_acc
);

    localparam int CX_W = (COUNT_BITS > TICKS_W) ? COUNT_BITS : TICKS_W;

    seq_state_t            seq_reg, seq_next;
    phase_t                phase_reg, phase_next;
    logic [TRIG_W-1:0]     timer_reg, timer_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [DIST_W-1:0]     last_reg, last_next;
    logic                  stop_reg, stop_next;
    logic                  fwd_reg, fwd_next;
    logic                  rev_reg, rev_next;
    logic [DIST_W-1:0]     raw_reg, raw_next;
    logic                  mv_reg, mv_next;
    logic [M_DATA_W-1:0]   mdata_reg, mdata_next;

    logic                  in_acc;
    logic                  out_free;
    logic                  start_req, echo_level, heading_forward, reverse_gear;
    logic [DIST_W-1:0]     acc_sat;
    logic [WEIGHT_W-1:0]   w_sat;
    logic [CX_W-1:0]       cnt_ext;
    logic                  trig;
    logic                  force_zero;

    assign start_req       = s_tdata[0];
    assign echo_level      = s_tdata[1];
    assign heading_forward = s_tdata[2];
    assign reverse_gear    = s_tdata[3];

    assign out_free = !mv_reg || m_tready;
    assign s_tready = (seq_reg == SQ_IDLE) && out_free;
    assign in_acc   = s_tvalid && s_tready;

    // Drop the rounding bits and saturate to the distance width
    assign acc_sat = (|mac_acc[ACC_W-1:DIST_W+8]) ? DIST_MAX : mac_acc[DIST_W+7:8];
    assign w_sat   = (cfg.filter_weight_q8 > WEIGHT_ONE) ? WEIGHT_ONE : cfg.filter_weight_q8;
    assign cnt_ext = CX_W'(count_reg);

    always_comb begin
        seq_next   = seq_reg;
        phase_next = phase_reg;
        timer_next = timer_reg;
        count_next = count_reg;
        last_next  = last_reg;
        stop_next  = stop_reg;
        fwd_next   = fwd_reg;
        rev_next   = rev_reg;
        raw_next   = raw_reg;
        mv_next    = mv_reg;
        mdata_next = mdata_reg;
        mac_op     = MAC_HOLD;
        mac_a      = '0;
        mac_b      = '0;
        trig       = 1'b0;
        force_zero = 1'b0;

        // Retire the held word once taken
        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        unique case (seq_reg)
            SQ_IDLE: begin
                if (in_acc) begin
                    unique case (phase_reg)
                        PH_IDLE: begin
                            if (start_req) begin
                                phase_next = PH_TRIG;
                                timer_next = TRIG_W'(1);
                                trig       = 1'b1;
                            end
                        end
                        PH_TRIG: begin
                            if (timer_reg < cfg.trigger_ticks) begin
                                timer_next = timer_reg + TRIG_W'(1);
                                trig       = 1'b1;
                            end else begin
                                phase_next = PH_WAIT;
                            end
                        end
                        PH_WAIT: begin
                            if (echo_level) begin
                                count_next = COUNT_BITS'(1);
                                phase_next = PH_COUNT;
                            end
                        end
                        PH_COUNT: begin
                            if (echo_level) begin
                                count_next = count_reg + COUNT_BITS'(1);
                            end else begin
                                // Echo fell: start count * scale on the shared unit
                                fwd_next = heading_forward;
                                rev_next = reverse_gear;
                                mac_op   = MAC_START;
                                mac_a    = AW'(count_reg);
                                mac_b    = MB_W'(cfg.scale_q16);
                                seq_next = SQ_RAW;
                            end
                        end
                    endcase
                    // Plain tick: emit the word right away
                    if (!((phase_reg == PH_COUNT) && !echo_level)) begin
                        mv_next    = 1'b1;
                        mdata_next = {M_PAD_W'(0), 1'b0, stop_reg, last_reg,
                                      DIST_W'(0), TICKS_W'(0), 1'b0, trig};
                    end
                end
            end
            SQ_RAW: begin
                // Latch raw distance, start (256 - w) * raw
                raw_next = acc_sat;
                mac_op   = MAC_START;
                mac_a    = AW'(acc_sat);
                mac_b    = MB_W'(WEIGHT_ONE - w_sat);
                seq_next = SQ_FILT;
            end
            SQ_FILT: begin
                // Add w * previous filtered distance
                mac_op   = MAC_ACC;
                mac_a    = AW'(last_reg);
                mac_b    = MB_W'(w_sat);
                seq_next = SQ_DONE;
            end
            SQ_DONE: begin
                if (out_free) begin
                    last_next = acc_sat;
                    // Stop hysteresis on the filtered distance
                    if (acc_sat < cfg.near_threshold) begin
                        if (fwd_reg) begin
                            stop_next  = 1'b1;
                            force_zero = 1'b1;
                        end else if (rev_reg) begin
                            stop_next = 1'b0;
                        end
                    end else if (acc_sat > cfg.far_threshold) begin
                        stop_next = 1'b0;
                    end
                    mv_next    = 1'b1;
                    mdata_next = {M_PAD_W'(0), force_zero, stop_next, acc_sat,
                                  raw_reg, cnt_ext[TICKS_W-1:0], 1'b1, 1'b0};
                    phase_next = PH_IDLE;
                    seq_next   = SQ_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg   <= SQ_IDLE;
            phase_reg <= PH_IDLE;
            timer_reg <= '0;
            count_reg <= '0;
            last_reg  <= '0;
            stop_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            seq_reg   <= seq_next;
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            count_reg <= count_next;
            last_reg  <= last_next;
            stop_reg  <= stop_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        fwd_reg   <= fwd_next;
        rev_reg   <= rev_next;
        raw_reg   <= raw_next;
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;

endmodule

// ----- design/ultrasonic_range_filter_stop_top.sv -----
// Ultrasonic range filter top: configuration registers, sequencer and shared MAC.
// A plain tick word is registered and shown the cycle after it is taken.
// A measurement-complete tick uses the shared multiply-accumulate unit (count * scale,
// then two filter products); its word is registered in SQ_DONE once the output is free.
// Throughput: one word per cycle, stalled while the output is held or the MAC is busy.
// Reset (aresetn, synchronous, active low) idles the block and loads default registers.
module ultrasonic_range_filter_stop_top
    import urfs_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [0] start_req, [1] echo_level, [2] heading_forward, [3] reverse_gear, [7:4] zero
    input  logic [S_DATA_W-1:0]  s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] trigger_out, [1] done_res, [17:2] echo_ticks, [37:18] raw_distance,
    // [57:38] filtered_distance, [58] stop_flag, [59] force_speed_zero, [63:60] zero
    output logic [M_DATA_W-1:0]  m_tdata
);

    localparam int AW    = (COUNT_BITS > DIST_W) ? COUNT_BITS : DIST_W;
    localparam int ACC_W = AW + MB_W + 1;

    cfg_t             cfg_reg, cfg_next;
    mac_op_t          mac_op;
    logic [AW-1:0]    mac_a;
    logic [MB_W-1:0]  mac_b;
    logic [ACC_W-1:0] mac_acc;

    // Decode register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TRIGGER_TICKS: cfg_next.trigger_ticks    = cfg_wdata[TRIG_W-1:0];
                CFG_SCALE_Q16:     cfg_next.scale_q16        = cfg_wdata[SCALE_W-1:0];
                CFG_WEIGHT_Q8:     cfg_next.filter_weight_q8 = cfg_wdata[WEIGHT_W-1:0];
                CFG_NEAR:          cfg_next.near_threshold   = cfg_wdata[DIST_W-1:0];
                CFG_FAR:           cfg_next.far_threshold    = cfg_wdata[DIST_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.trigger_ticks    <= RST_TRIGGER_TICKS;
            cfg_reg.scale_q16        <= RST_SCALE_Q16;
            cfg_reg.filter_weight_q8 <= RST_WEIGHT_Q8;
            cfg_reg.near_threshold   <= RST_NEAR;
            cfg_reg.far_threshold    <= RST_FAR;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    urfs_ctrl #(
        .COUNT_BITS (COUNT_BITS),
        .AW         (AW),
        .ACC_W      (ACC_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .mac_op   (mac_op),
        .mac_a    (mac_a),
        .mac_b    (mac_b),
        .mac_acc  (mac_acc)
    );

    urfs_mac #(
        .AW    (AW),
        .ACC_W (ACC_W)
    ) u_mac (
        .aclk (aclk),
        .op   (mac_op),
        .a    (mac_a),
        .b    (mac_b),
        .acc  (mac_acc)
    );

endmodule

// ----- design/urfs_checker.sv -----
// Port-level checker for the range filter, bound to the top level.
`include "ultrasonic_range_filter_stop_top_assert.svh"

module urfs_checker
    import urfs_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // A stalled result word holds
    `URFS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // Speed forcing only on a done word that also raises the stop flag
    `URFS_ASSERT_IMPL(a_force_done, aclk, aresetn, m_tvalid && m_tdata[59], m_tdata[1] && m_tdata[58], "force without done and stop")

    // Ticks and raw distance stay zero outside done words
    `URFS_ASSERT_IMPL(a_idle_zero, aclk, aresetn, m_tvalid && !m_tdata[1], m_tdata[37:2] == '0, "measurement fields set on a plain tick")

    // Trigger is never driven on the completing tick
    `URFS_ASSERT_IMPL(a_trig_done, aclk, aresetn, m_tvalid && m_tdata[1], !m_tdata[0], "trigger high on done word")

endmodule

bind ultrasonic_range_filter_stop_top urfs_checker u_urfs_checker (.*);
